FILE: src/nearest_blob_steering_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef NEAREST_BLOB_STEERING_MACROS_SVH
`define NEAREST_BLOB_STEERING_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define NBS_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define NBS_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/nbs_pkg.sv
`timescale 1ns / 1ps

package nbs_pkg;

  // Fixed field widths
  localparam int AREA_BITS     = 17;
  localparam int MIN_DSQ_BITS  = 19;
  localparam int GAIN_BITS     = 8;
  localparam int BASE_BITS     = 8;
  localparam int SPEED_BITS    = 19;
  localparam int CFG_DATA_BITS = 19;
  localparam int CFG_ADDR_BITS = 3;

  // Queue between front and back
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = 2;
  localparam int FIFO_CNT_BITS = 3;

  // Register reset values
  localparam int RST_ROBOT_X    = 250;
  localparam int RST_ROBOT_Y    = 250;
  localparam int RST_MIN_AREA   = 5;
  localparam int RST_MIN_DSQ    = 100;
  localparam int RST_GAIN       = 24;
  localparam int RST_BASE_SPEED = 50;

  // Default points for a side with no blob
  localparam int DEF_LEFT_X  = 50;
  localparam int DEF_RIGHT_X = 450;
  localparam int DEF_Y       = 50;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_ROBOT_X     = 3'd0,
    REG_ROBOT_Y     = 3'd1,
    REG_MIN_AREA    = 3'd2,
    REG_MIN_DIST_SQ = 3'd3,
    REG_GAIN        = 3'd4,
    REG_BASE_SPEED  = 3'd5,
    REG_RUN_ENABLE  = 3'd6
  } nbs_reg_t;

  // Classification flags of one queued word
  typedef struct packed {
    logic last;   // last blob of the frame
    logic left;   // blob lies left of the robot column
    logic keep;   // passes area and distance filters
  } nbs_cls_t;

endpackage

FILE: src/nearest_blob_steering.sv
// From acceptance of a frame's last word to out_tvalid the result passes
//   2 front stages, 1 queue slot and 4 result stages: snapshot, error, product, output.
// One blob word per cycle unless stalled; the nearest-blob compare runs each cycle.
// One result word per frame; a 4-deep queue lets front and back stall separately.
// Reset (rst_n low, synchronous): registers take their documented defaults,
//   both sides hold no candidate and all pipelines are emptied.
`timescale 1ns / 1ps

module nearest_blob_steering #(
  parameter int LABEL_BITS = 8,
  parameter int X_BITS     = 9,
  parameter int Y_BITS     = 8
) (
  input  logic clk,
  input  logic rst_n,
  // slave side: blob_label, blob_area, centroid_x, centroid_y (low to high)
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [((LABEL_BITS + nbs_pkg::AREA_BITS + X_BITS + Y_BITS + 7) / 8) * 8 - 1:0]
               in_tdata,
  input  logic in_tlast,    // frame_last
  // master side: left_x, left_y, right_x, right_y, left_found, right_found,
  //   left_pick, right_pick, speed_left, speed_right (low to high)
  output logic out_tvalid,
  input  logic out_tready,
  output logic [((2 * X_BITS + 2 * Y_BITS + 2 + 2 * LABEL_BITS + 2 * nbs_pkg::SPEED_BITS + 7)
                / 8) * 8 - 1:0] out_tdata,
  // configuration writes
  input  logic                               cfg_we,
  input  logic [nbs_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [nbs_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import nbs_pkg::*;

  localparam int XY_MAX   = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;
  localparam int DSQ_BITS = 2 * XY_MAX + 1;
  localparam int Q_BITS   = 3 + DSQ_BITS + X_BITS + Y_BITS + LABEL_BITS;
  localparam int OUT_RAW  = 2 * X_BITS + 2 * Y_BITS + 2 + 2 * LABEL_BITS + 2 * SPEED_BITS;
  localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8;

  // configuration registers
  logic [X_BITS-1:0]       robot_x_r;
  logic [Y_BITS-1:0]       robot_y_r;
  logic [AREA_BITS-1:0]    min_area_r;
  logic [MIN_DSQ_BITS-1:0] min_dsq_r;
  logic [GAIN_BITS-1:0]    gain_r;
  logic [BASE_BITS-1:0]    base_r;
  logic                    run_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      robot_x_r  <= X_BITS'(RST_ROBOT_X);
      robot_y_r  <= Y_BITS'(RST_ROBOT_Y);
      min_area_r <= AREA_BITS'(RST_MIN_AREA);
      min_dsq_r  <= MIN_DSQ_BITS'(RST_MIN_DSQ);
      gain_r     <= GAIN_BITS'(RST_GAIN);
      base_r     <= BASE_BITS'(RST_BASE_SPEED);
      run_r      <= 1'b0;
    end else if (cfg_we) begin
      case (nbs_reg_t'(cfg_addr))
        REG_ROBOT_X:     robot_x_r  <= cfg_wdata[X_BITS-1:0];
        REG_ROBOT_Y:     robot_y_r  <= cfg_wdata[Y_BITS-1:0];
        REG_MIN_AREA:    min_area_r <= cfg_wdata[AREA_BITS-1:0];
        REG_MIN_DIST_SQ: min_dsq_r  <= cfg_wdata[MIN_DSQ_BITS-1:0];
        REG_GAIN:        gain_r     <= cfg_wdata[GAIN_BITS-1:0];
        REG_BASE_SPEED:  base_r     <= cfg_wdata[BASE_BITS-1:0];
        REG_RUN_ENABLE:  run_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input word unpacking
  logic [LABEL_BITS-1:0] in_label;
  logic [AREA_BITS-1:0]  in_area;
  logic [X_BITS-1:0]     in_x;
  logic [Y_BITS-1:0]     in_y;

  assign in_label = in_tdata[LABEL_BITS-1:0];
  assign in_area  = in_tdata[LABEL_BITS +: AREA_BITS];
  assign in_x     = in_tdata[LABEL_BITS + AREA_BITS +: X_BITS];
  assign in_y     = in_tdata[LABEL_BITS + AREA_BITS + X_BITS +: Y_BITS];

  // front: distance and filters
  logic                  f_valid, f_ready;
  nbs_cls_t              f_cls;
  logic [DSQ_BITS-1:0]   f_dsq;
  logic [X_BITS-1:0]     f_x;
  logic [Y_BITS-1:0]     f_y;
  logic [LABEL_BITS-1:0] f_label;

  nbs_front #(
    .LABEL_BITS (LABEL_BITS),
    .X_BITS     (X_BITS),
    .Y_BITS     (Y_BITS),
    .DSQ_BITS   (DSQ_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_label    (in_label),
    .in_area     (in_area),
    .in_x        (in_x),
    .in_y        (in_y),
    .in_last     (in_tlast),
    .robot_x     (robot_x_r),
    .robot_y     (robot_y_r),
    .min_area    (min_area_r),
    .min_dist_sq (min_dsq_r),
    .push_valid  (f_valid),
    .push_ready  (f_ready),
    .push_cls    (f_cls),
    .push_dsq    (f_dsq),
    .push_x      (f_x),
    .push_y      (f_y),
    .push_label  (f_label)
  );

  // queue between front and back
  logic [Q_BITS-1:0] q_in, q_out;
  logic              q_valid, q_pop;

  assign q_in = {f_label, f_y, f_x, f_dsq, f_cls};

  nbs_fifo #(
    .WIDTH (Q_BITS)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (q_in),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_out)
  );

  nbs_cls_t              h_cls;
  logic [DSQ_BITS-1:0]   h_dsq;
  logic [X_BITS-1:0]     h_x;
  logic [Y_BITS-1:0]     h_y;
  logic [LABEL_BITS-1:0] h_label;

  assign h_cls   = q_out[2:0];
  assign h_dsq   = q_out[3 +: DSQ_BITS];
  assign h_x     = q_out[3 + DSQ_BITS +: X_BITS];
  assign h_y     = q_out[3 + DSQ_BITS + X_BITS +: Y_BITS];
  assign h_label = q_out[3 + DSQ_BITS + X_BITS + Y_BITS +: LABEL_BITS];

  // back: nearest selection and steering
  logic [X_BITS-1:0]     o_lx, o_rx;
  logic [Y_BITS-1:0]     o_ly, o_ry;
  logic                  o_lf, o_rf;
  logic [LABEL_BITS-1:0] o_lp, o_rp;
  logic signed [SPEED_BITS-1:0] o_sl, o_sr;

  nbs_back #(
    .LABEL_BITS (LABEL_BITS),
    .X_BITS     (X_BITS),
    .Y_BITS     (Y_BITS),
    .DSQ_BITS   (DSQ_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (q_valid),
    .pop             (q_pop),
    .head_cls        (h_cls),
    .head_dsq        (h_dsq),
    .head_x          (h_x),
    .head_y          (h_y),
    .head_label      (h_label),
    .robot_x         (robot_x_r),
    .gain            (gain_r),
    .base_speed      (base_r),
    .run_enable      (run_r),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_left_x      (o_lx),
    .out_left_y      (o_ly),
    .out_right_x     (o_rx),
    .out_right_y     (o_ry),
    .out_left_found  (o_lf),
    .out_right_found (o_rf),
    .out_left_pick   (o_lp),
    .out_right_pick  (o_rp),
    .out_speed_left  (o_sl),
    .out_speed_right (o_sr)
  );

  // result word packing, zero filled to whole bytes
  logic [OUT_RAW-1:0] out_raw;

  assign out_raw   = {o_sr, o_sl, o_rp, o_lp, o_rf, o_lf, o_ry, o_rx, o_ly, o_lx};
  assign out_tdata = OUT_W'(out_raw);

endmodule

FILE: src/nbs_front.sv
`timescale 1ns / 1ps
`include "nearest_blob_steering_macros.svh"

module nbs_front #(
  parameter int LABEL_BITS = 8,
  parameter int X_BITS     = 9,
  parameter int Y_BITS     = 8,
  parameter int DSQ_BITS   = 19
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [LABEL_BITS-1:0]          in_label,
  input  logic [nbs_pkg::AREA_BITS-1:0]  in_area,
  input  logic [X_BITS-1:0]              in_x,
  input  logic [Y_BITS-1:0]              in_y,
  input  logic                           in_last,
  input  logic [X_BITS-1:0]              robot_x,
  input  logic [Y_BITS-1:0]              robot_y,
  input  logic [nbs_pkg::AREA_BITS-1:0]  min_area,
  input  logic [nbs_pkg::MIN_DSQ_BITS-1:0] min_dist_sq,
  output logic                           push_valid,
  input  logic                           push_ready,
  output nbs_pkg::nbs_cls_t              push_cls,
  output logic [DSQ_BITS-1:0]            push_dsq,
  output logic [X_BITS-1:0]              push_x,
  output logic [Y_BITS-1:0]              push_y,
  output logic [LABEL_BITS-1:0]          push_label
);
  import nbs_pkg::*;

  localparam int CMP_BITS = (DSQ_BITS > MIN_DSQ_BITS) ? DSQ_BITS : MIN_DSQ_BITS;

  // stage A: absolute offsets, side and area check
  logic                  va_r;
  logic [LABEL_BITS-1:0] lab_a_r;
  logic [X_BITS-1:0]     x_a_r;
  logic [Y_BITS-1:0]     y_a_r;
  logic                  last_a_r, left_a_r, aok_a_r;
  logic [X_BITS-1:0]     dx_a_r;
  logic [Y_BITS-1:0]     dy_a_r;

  // stage B: squared offsets
  logic                  vb_r;
  logic [LABEL_BITS-1:0] lab_b_r;
  logic [X_BITS-1:0]     x_b_r;
  logic [Y_BITS-1:0]     y_b_r;
  logic                  last_b_r, left_b_r, aok_b_r;
  logic [2*X_BITS-1:0]   sqx_b_r;
  logic [2*Y_BITS-1:0]   sqy_b_r;

  logic rdy_a, rdy_b;
  logic [DSQ_BITS-1:0] dsq;

  assign rdy_b    = !vb_r || push_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  // stage A registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (rdy_a) begin
      va_r <= in_valid;
    end
    if (rdy_a) begin
      lab_a_r  <= in_label;
      x_a_r    <= in_x;
      y_a_r    <= in_y;
      last_a_r <= in_last;
      left_a_r <= (in_x < robot_x);
      aok_a_r  <= (in_area >= min_area);
      dx_a_r   <= (in_x >= robot_x) ? in_x - robot_x : robot_x - in_x;
      dy_a_r   <= (in_y >= robot_y) ? in_y - robot_y : robot_y - in_y;
    end
  end

  // stage B registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (rdy_b) begin
      vb_r <= va_r;
    end
    if (rdy_b) begin
      lab_b_r  <= lab_a_r;
      x_b_r    <= x_a_r;
      y_b_r    <= y_a_r;
      last_b_r <= last_a_r;
      left_b_r <= left_a_r;
      aok_b_r  <= aok_a_r;
      sqx_b_r  <= dx_a_r * dx_a_r;
      sqy_b_r  <= dy_a_r * dy_a_r;
    end
  end

  // distance sum and filter toward the queue
  assign dsq = DSQ_BITS'(sqx_b_r) + DSQ_BITS'(sqy_b_r);

  always_comb begin
    push_valid    = vb_r;
    push_cls.last = last_b_r;
    push_cls.left = left_b_r;
    push_cls.keep = aok_b_r && (CMP_BITS'(dsq) >= CMP_BITS'(min_dist_sq));
    push_dsq      = dsq;
    push_x        = x_b_r;
    push_y        = y_b_r;
    push_label    = lab_b_r;
  end

  `NBS_ASSERT_NXT(a_front_hold, clk, rst_n, vb_r && !push_ready, vb_r && $stable(dsq), "front word lost under stall")
  `NBS_ASSERT_IMP(a_front_left, clk, rst_n, push_valid && push_cls.left, push_x < robot_x || !$stable(robot_x), "left word not left of robot column")
  `NBS_ASSERT_NXT(a_front_adv, clk, rst_n, va_r && rdy_b, vb_r, "stage A word dropped")

endmodule

FILE: src/nbs_fifo.sv
`timescale 1ns / 1ps
`include "nearest_blob_steering_macros.svh"

module nbs_fifo #(
  parameter int WIDTH = 48
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);
  import nbs_pkg::*;

  logic [WIDTH-1:0]         mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                     do_push, do_pop;

  assign push_ready = (cnt_r != FIFO_CNT_BITS'(FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = mem_r[rd_ptr_r];

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `NBS_ASSERT_IMP(a_fifo_bound, clk, rst_n, 1'b1, cnt_r <= FIFO_CNT_BITS'(FIFO_DEPTH), "queue overfilled")
  `NBS_ASSERT_NXT(a_fifo_up, clk, rst_n, do_push && !do_pop, cnt_r == $past(cnt_r) + 1'b1, "queue count missed a push")
  `NBS_ASSERT_IMP(a_fifo_ptr, clk, rst_n, 1'b1, FIFO_PTR_BITS'(wr_ptr_r - rd_ptr_r) == FIFO_PTR_BITS'(cnt_r), "queue pointers disagree with count")

endmodule

FILE: src/nbs_back.sv
`timescale 1ns / 1ps
`include "nearest_blob_steering_macros.svh"

module nbs_back #(
  parameter int LABEL_BITS = 8,
  parameter int X_BITS     = 9,
  parameter int Y_BITS     = 8,
  parameter int DSQ_BITS   = 19
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            head_valid,
  output logic                            pop,
  input  nbs_pkg::nbs_cls_t               head_cls,
  input  logic [DSQ_BITS-1:0]             head_dsq,
  input  logic [X_BITS-1:0]               head_x,
  input  logic [Y_BITS-1:0]               head_y,
  input  logic [LABEL_BITS-1:0]           head_label,
  input  logic [X_BITS-1:0]               robot_x,
  input  logic [nbs_pkg::GAIN_BITS-1:0]   gain,
  input  logic [nbs_pkg::BASE_BITS-1:0]   base_speed,
  input  logic                            run_enable,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [X_BITS-1:0]               out_left_x,
  output logic [Y_BITS-1:0]               out_left_y,
  output logic [X_BITS-1:0]               out_right_x,
  output logic [Y_BITS-1:0]               out_right_y,
  output logic                            out_left_found,
  output logic                            out_right_found,
  output logic [LABEL_BITS-1:0]           out_left_pick,
  output logic [LABEL_BITS-1:0]           out_right_pick,
  output logic signed [nbs_pkg::SPEED_BITS-1:0] out_speed_left,
  output logic signed [nbs_pkg::SPEED_BITS-1:0] out_speed_right
);
  import nbs_pkg::*;

  localparam logic [DSQ_BITS-1:0] DSQ_NONE = '1;
  localparam int ERR_BITS  = X_BITS + 1;
  localparam int PROD_BITS = ERR_BITS + GAIN_BITS + 1;
  localparam int ACC_A     = (PROD_BITS + 1 > BASE_BITS + 6) ? PROD_BITS + 1 : BASE_BITS + 6;
  localparam int ACC_BITS  = (ACC_A > SPEED_BITS) ? ACC_A : SPEED_BITS;

  // per-side nearest blob
  logic [DSQ_BITS-1:0]   l_dsq_r, l_dsq_nxt, r_dsq_r, r_dsq_nxt;
  logic [X_BITS-1:0]     l_x_r, l_x_nxt, r_x_r, r_x_nxt;
  logic [Y_BITS-1:0]     l_y_r, l_y_nxt, r_y_r, r_y_nxt;
  logic [LABEL_BITS-1:0] l_lab_r, l_lab_nxt, r_lab_r, r_lab_nxt;
  logic                  l_take, r_take;

  // result pipeline: snapshot, error, product, output
  logic                  v1_r, v2_r, v3_r, v4_r;
  logic                  rdy1, rdy2, rdy3, rdy4;
  logic                  lf1_r, rf1_r, lf2_r, rf2_r, lf3_r, rf3_r;
  logic [X_BITS-1:0]     lx1_r, rx1_r, lx2_r, rx2_r, lx3_r, rx3_r;
  logic [Y_BITS-1:0]     ly1_r, ry1_r, ly2_r, ry2_r, ly3_r, ry3_r;
  logic [LABEL_BITS-1:0] lp1_r, rp1_r, lp2_r, rp2_r, lp3_r, rp3_r;
  logic signed [ERR_BITS-1:0]  err2_r;
  logic signed [PROD_BITS-1:0] prod3_r;
  logic [X_BITS:0]             pair_sum;
  logic [X_BITS-1:0]           mid;
  logic signed [ACC_BITS-1:0]  base16, sl_full, sr_full;

  assign rdy4 = !v4_r || out_ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  // a frame's last word needs a free snapshot slot
  assign pop = head_valid && (!head_cls.last || rdy1);

  // nearest-blob update, first one wins a tie
  always_comb begin
    l_take    = head_cls.keep && head_cls.left && (head_dsq < l_dsq_r);
    r_take    = head_cls.keep && !head_cls.left && (head_dsq < r_dsq_r);
    l_dsq_nxt = l_take ? head_dsq : l_dsq_r;
    l_x_nxt   = l_take ? head_x : l_x_r;
    l_y_nxt   = l_take ? head_y : l_y_r;
    l_lab_nxt = l_take ? head_label : l_lab_r;
    r_dsq_nxt = r_take ? head_dsq : r_dsq_r;
    r_x_nxt   = r_take ? head_x : r_x_r;
    r_y_nxt   = r_take ? head_y : r_y_r;
    r_lab_nxt = r_take ? head_label : r_lab_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_dsq_r <= DSQ_NONE;
      r_dsq_r <= DSQ_NONE;
      l_x_r   <= '0;
      l_y_r   <= '0;
      l_lab_r <= '0;
      r_x_r   <= '0;
      r_y_r   <= '0;
      r_lab_r <= '0;
    end else if (pop) begin
      if (head_cls.last) begin
        l_dsq_r <= DSQ_NONE;
        r_dsq_r <= DSQ_NONE;
        l_x_r   <= '0;
        l_y_r   <= '0;
        l_lab_r <= '0;
        r_x_r   <= '0;
        r_y_r   <= '0;
        r_lab_r <= '0;
      end else begin
        l_dsq_r <= l_dsq_nxt;
        r_dsq_r <= r_dsq_nxt;
        l_x_r   <= l_x_nxt;
        l_y_r   <= l_y_nxt;
        l_lab_r <= l_lab_nxt;
        r_x_r   <= r_x_nxt;
        r_y_r   <= r_y_nxt;
        r_lab_r <= r_lab_nxt;
      end
    end
  end

  // valid bits of the result pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= pop && head_cls.last;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // snapshot with defaults for empty sides
  always_ff @(posedge clk) begin
    if (rdy1) begin
      lf1_r <= (l_dsq_nxt != DSQ_NONE);
      rf1_r <= (r_dsq_nxt != DSQ_NONE);
      lx1_r <= (l_dsq_nxt != DSQ_NONE) ? l_x_nxt : X_BITS'(DEF_LEFT_X);
      ly1_r <= (l_dsq_nxt != DSQ_NONE) ? l_y_nxt : Y_BITS'(DEF_Y);
      rx1_r <= (r_dsq_nxt != DSQ_NONE) ? r_x_nxt : X_BITS'(DEF_RIGHT_X);
      ry1_r <= (r_dsq_nxt != DSQ_NONE) ? r_y_nxt : Y_BITS'(DEF_Y);
      lp1_r <= (l_dsq_nxt != DSQ_NONE) ? l_lab_nxt : '0;
      rp1_r <= (r_dsq_nxt != DSQ_NONE) ? r_lab_nxt : '0;
    end
  end

  // steering error against the midpoint
  assign pair_sum = {1'b0, lx1_r} + {1'b0, rx1_r};
  assign mid      = pair_sum[X_BITS:1];

  always_ff @(posedge clk) begin
    if (rdy2) begin
      err2_r <= $signed({1'b0, robot_x}) - $signed({1'b0, mid});
      lf2_r  <= lf1_r;
      rf2_r  <= rf1_r;
      lx2_r  <= lx1_r;
      ly2_r  <= ly1_r;
      rx2_r  <= rx1_r;
      ry2_r  <= ry1_r;
      lp2_r  <= lp1_r;
      rp2_r  <= rp1_r;
    end
  end

  // gain times error
  always_ff @(posedge clk) begin
    if (rdy3) begin
      prod3_r <= $signed({1'b0, gain}) * err2_r;
      lf3_r   <= lf2_r;
      rf3_r   <= rf2_r;
      lx3_r   <= lx2_r;
      ly3_r   <= ly2_r;
      rx3_r   <= rx2_r;
      ry3_r   <= ry2_r;
      lp3_r   <= lp2_r;
      rp3_r   <= rp2_r;
    end
  end

  // wheel speeds
  assign base16  = $signed(ACC_BITS'({base_speed, 4'b0000}));
  assign sl_full = base16 - ACC_BITS'(prod3_r);
  assign sr_full = ACC_BITS'(0) - (base16 + ACC_BITS'(prod3_r));

  always_ff @(posedge clk) begin
    if (rdy4) begin
      out_left_x      <= lx3_r;
      out_left_y      <= ly3_r;
      out_right_x     <= rx3_r;
      out_right_y     <= ry3_r;
      out_left_found  <= lf3_r;
      out_right_found <= rf3_r;
      out_left_pick   <= lp3_r;
      out_right_pick  <= rp3_r;
      out_speed_left  <= run_enable ? sl_full[SPEED_BITS-1:0] : '0;
      out_speed_right <= run_enable ? sr_full[SPEED_BITS-1:0] : '0;
    end
  end

  assign out_valid = v4_r;

  `NBS_ASSERT_NXT(a_back_clear, clk, rst_n, pop && head_cls.last, l_dsq_r == DSQ_NONE && r_dsq_r == DSQ_NONE, "side state not cleared after frame end")
  `NBS_ASSERT_IMP(a_back_dflt, clk, rst_n, out_valid && !out_left_found, out_left_x == X_BITS'(DEF_LEFT_X) && out_left_pick == '0, "empty left side without default")
  `NBS_ASSERT_IMP(a_back_stall, clk, rst_n, head_valid && head_cls.last && !rdy1, !pop, "frame end popped with no snapshot slot")

endmodule

FILE: sim/nearest_blob_steering_tb.sv
`timescale 1ns / 1ps

module nearest_blob_steering_tb;
  import nbs_pkg::*;

  // One blob word as sent on the input stream
  typedef struct packed {
    logic [7:0]  label;
    logic [16:0] area;
    logic [8:0]  cx;
    logic [7:0]  cy;
    logic        last;
  } blob_t;

  // One steering word as produced per frame
  typedef struct packed {
    logic [8:0]  lx;
    logic [7:0]  ly;
    logic [8:0]  rx;
    logic [7:0]  ry;
    logic        lf;
    logic        rf;
    logic [7:0]  lp;
    logic [7:0]  rp;
    logic [18:0] sl;
    logic [18:0] sr;
  } steer_t;

  localparam logic [18:0] NO_CAND = '1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // blob_label, blob_area, centroid_x, centroid_y
  logic        in_tlast = 1'b0;  // frame_last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;        // lx, ly, rx, ry, lf, rf, lpick, rpick, speed_l, speed_r
  logic        cfg_we = 1'b0;
  nbs_reg_t    cfg_addr = REG_ROBOT_X;
  logic [18:0] cfg_wdata = '0;

  nearest_blob_steering u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Register shadow
  logic [8:0]  sh_robot_x = 9'(RST_ROBOT_X);
  logic [7:0]  sh_robot_y = 8'(RST_ROBOT_Y);
  logic [16:0] sh_min_area = 17'(RST_MIN_AREA);
  logic [18:0] sh_min_dsq = 19'(RST_MIN_DSQ);
  logic [7:0]  sh_gain = 8'(RST_GAIN);
  logic [7:0]  sh_base = 8'(RST_BASE_SPEED);
  logic        sh_run = 1'b0;

  // Nearest candidate per side
  logic [18:0] lft_dsq = NO_CAND;
  logic [8:0]  lft_x = '0;
  logic [7:0]  lft_y = '0;
  logic [7:0]  lft_lab = '0;
  logic [18:0] rgt_dsq = NO_CAND;
  logic [8:0]  rgt_x = '0;
  logic [7:0]  rgt_y = '0;
  logic [7:0]  rgt_lab = '0;

  blob_t  blob_q[$];
  steer_t steer_q[$];

  int errors = 0;
  int n_blobs = 0;
  int n_frames = 0;
  int n_checked = 0;
  int n_settings = 0;
  int n_left_hits = 0;
  int n_right_hits = 0;

  logic in_fire = 1'b0;
  int   burst_left = 1;
  int   gap_left = 0;
  int   rdy_cnt = 0;
  blob_t drv_blob;

  // Fold one blob into the per-side nearest picks; returns 1 on frame end
  function automatic bit fold_blob(input blob_t b, output steer_t res);
    int dx, dy, dsq, err, sl, sr, base16;
    dx = (b.cx > sh_robot_x) ? int'(b.cx) - int'(sh_robot_x) : int'(sh_robot_x) - int'(b.cx);
    dy = (b.cy > sh_robot_y) ? int'(b.cy) - int'(sh_robot_y) : int'(sh_robot_y) - int'(b.cy);
    dsq = dx * dx + dy * dy;
    res = '0;
    if (b.area >= sh_min_area && dsq >= int'(sh_min_dsq)) begin
      if (b.cx < sh_robot_x) begin
        if (dsq < int'(lft_dsq)) begin
          lft_dsq = dsq[18:0];
          lft_x = b.cx;
          lft_y = b.cy;
          lft_lab = b.label;
        end
      end else if (dsq < int'(rgt_dsq)) begin
        rgt_dsq = dsq[18:0];
        rgt_x = b.cx;
        rgt_y = b.cy;
        rgt_lab = b.label;
      end
    end
    if (!b.last) return 1'b0;

    res.lf = (lft_dsq != NO_CAND);
    res.rf = (rgt_dsq != NO_CAND);
    res.lx = res.lf ? lft_x : 9'(DEF_LEFT_X);
    res.ly = res.lf ? lft_y : 8'(DEF_Y);
    res.rx = res.rf ? rgt_x : 9'(DEF_RIGHT_X);
    res.ry = res.rf ? rgt_y : 8'(DEF_Y);
    res.lp = res.lf ? lft_lab : 8'd0;
    res.rp = res.rf ? rgt_lab : 8'd0;
    err = int'(sh_robot_x) - ((int'(res.lx) + int'(res.rx)) >>> 1);
    base16 = int'(sh_base) * 16;
    sl = 0;
    sr = 0;
    if (sh_run) begin
      sl = base16 - int'(sh_gain) * err;
      sr = -(base16 + int'(sh_gain) * err);
    end
    res.sl = sl[18:0];
    res.sr = sr[18:0];

    // frame done, drop both picks
    lft_dsq = NO_CAND;
    lft_x = '0;
    lft_y = '0;
    lft_lab = '0;
    rgt_dsq = NO_CAND;
    rgt_x = '0;
    rgt_y = '0;
    rgt_lab = '0;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [18:0] want,
                             input logic [18:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Monitor: checks result words, predicts from accepted blob words
  always @(posedge clk) begin
    steer_t got, want, res;
    blob_t  b;
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.lx = out_tdata[8:0];
        got.ly = out_tdata[16:9];
        got.rx = out_tdata[25:17];
        got.ry = out_tdata[33:26];
        got.lf = out_tdata[34];
        got.rf = out_tdata[35];
        got.lp = out_tdata[43:36];
        got.rp = out_tdata[51:44];
        got.sl = out_tdata[70:52];
        got.sr = out_tdata[89:71];
        if (steer_q.size() == 0) begin
          errors++;
          $display("%0t: result word with none expected, actual %0h", $time, out_tdata);
        end else begin
          want = steer_q.pop_front();
          n_checked++;
          check_field("left_x", 19'(want.lx), 19'(got.lx));
          check_field("left_y", 19'(want.ly), 19'(got.ly));
          check_field("right_x", 19'(want.rx), 19'(got.rx));
          check_field("right_y", 19'(want.ry), 19'(got.ry));
          check_field("left_found", 19'(want.lf), 19'(got.lf));
          check_field("right_found", 19'(want.rf), 19'(got.rf));
          check_field("left_pick", 19'(want.lp), 19'(got.lp));
          check_field("right_pick", 19'(want.rp), 19'(got.rp));
          check_field("speed_left", want.sl, got.sl);
          check_field("speed_right", want.sr, got.sr);
        end
      end
      if (in_tvalid && in_tready) begin
        b.label = in_tdata[7:0];
        b.area = in_tdata[24:8];
        b.cx = in_tdata[33:25];
        b.cy = in_tdata[41:34];
        b.last = in_tlast;
        n_blobs++;
        if (fold_blob(b, res)) begin
          n_frames++;
          n_left_hits += int'(res.lf);
          n_right_hits += int'(res.rf);
          steer_q.push_back(res);
        end
      end
    end
  end

  // Driver: bursts of blob words with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fire) begin
      // hold the word until taken
    end else if (gap_left != 0) begin
      gap_left <= gap_left - 1;
      in_tvalid <= 1'b0;
    end else if (blob_q.size() != 0) begin
      drv_blob = blob_q.pop_front();
      in_tvalid <= 1'b1;
      in_tdata <= {6'b0, drv_blob.cy, drv_blob.cx, drv_blob.area, drv_blob.label};
      in_tlast <= drv_blob.last;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Receiver: always ready, random, periodic and long stalls in turn
  always @(negedge clk) begin
    rdy_cnt <= rdy_cnt + 1;
    case (rdy_cnt[7:6])
      2'd0: begin
        out_tready <= 1'b1;
      end
      2'd1: begin
        out_tready <= ($urandom_range(0, 1) == 1);
      end
      2'd2: begin
        out_tready <= (rdy_cnt[2:0] != 3'd0);
      end
      default: begin
        out_tready <= (rdy_cnt[4:0] == 5'd0);
      end
    endcase
  end

  task automatic push_blob(input int label, input int area, input int cx, input int cy,
                           input bit last);
    blob_t b;
    b.label = label[7:0];
    b.area = area[16:0];
    b.cx = cx[8:0];
    b.cy = cy[7:0];
    b.last = last;
    blob_q.push_back(b);
  endtask

  // Register write with junk above the register width
  task automatic write_reg(input nbs_reg_t idx, input int value, input int width);
    logic [18:0] junk;
    junk = 19'($urandom) << width;
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= (width < 19) ? (19'(value) | junk) : 19'(value);
    case (idx)
      REG_ROBOT_X:     sh_robot_x = value[8:0];
      REG_ROBOT_Y:     sh_robot_y = value[7:0];
      REG_MIN_AREA:    sh_min_area = value[16:0];
      REG_MIN_DIST_SQ: sh_min_dsq = value[18:0];
      REG_GAIN:        sh_gain = value[7:0];
      REG_BASE_SPEED:  sh_base = value[7:0];
      REG_RUN_ENABLE:  sh_run = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int rx, input int ry, input int ma, input int md,
                                input int g, input int bs, input int en);
    write_reg(REG_ROBOT_X, rx, 9);
    write_reg(REG_ROBOT_Y, ry, 8);
    write_reg(REG_MIN_AREA, ma, 17);
    write_reg(REG_MIN_DIST_SQ, md, 19);
    write_reg(REG_GAIN, g, 8);
    write_reg(REG_BASE_SPEED, bs, 8);
    write_reg(REG_RUN_ENABLE, en, 1);
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Sender holds off until every frame result is back, then lets the pipe drain
  task automatic drain_all();
    @(posedge clk);
    while (blob_q.size() != 0 || in_tvalid || steer_q.size() != 0) @(posedge clk);
    repeat (10) @(negedge clk);
  endtask

  // Fixed frames around the default robot point
  task automatic queue_directed();
    push_blob(0, 0, 0, 0, 1);            // lone last word, filtered by area
    push_blob(255, 131071, 0, 0, 0);     // far corner, left
    push_blob(1, 5, 511, 255, 0);        // area at threshold, right
    push_blob(2, 6, 511, 245, 0);        // same distance, first one stays
    push_blob(3, 4, 249, 250, 1);        // area just below threshold
    push_blob(4, 9, 241, 250, 0);        // too close
    push_blob(0, 9, 240, 250, 0);        // distance at threshold, label zero
    push_blob(5, 9, 250, 240, 0);        // on the robot column goes right
    push_blob(6, 100, 255, 200, 1);
    push_blob(7, 50, 10, 100, 1);        // left only
    push_blob(8, 50, 400, 10, 0);        // right only, nearer one replaces
    push_blob(9, 50, 300, 250, 1);
  endtask

  function automatic int near_val(input int center, input int spread, input int hi);
    int v;
    v = center + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > hi) v = hi;
    return v;
  endfunction

  // Random frames, mostly several blobs, some with ties
  task automatic queue_random(input int count);
    int n, len, label, area, cx, cy, pcx, pcy, parea;
    n = 0;
    while (n < count) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      pcx = 0;
      pcy = 0;
      parea = 0;
      for (int i = 0; i < len; i++) begin
        label = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 255);
        case ($urandom_range(0, 2))
          0: area = near_val(int'(sh_min_area), 1, 131071);
          1: area = $urandom_range(0, 1000);
          default: area = $urandom_range(0, 131071);
        endcase
        cx = ($urandom_range(0, 3) == 0) ? near_val(int'(sh_robot_x), 12, 511)
                                         : $urandom_range(0, 511);
        cy = ($urandom_range(0, 3) == 0) ? near_val(int'(sh_robot_y), 12, 255)
                                         : $urandom_range(0, 255);
        if (i != 0 && $urandom_range(0, 7) == 0) begin
          cx = pcx;
          cy = pcy;
          area = parea;
        end
        push_blob(label, area, cx, cy, i == len - 1);
        pcx = cx;
        pcy = cy;
        parea = area;
        n++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings, wheels off
    n_settings++;
    queue_directed();
    drain_all();

    // same frames with wheels on
    apply_settings(250, 250, 5, 100, 24, 50, 1);
    queue_directed();
    drain_all();

    // random settings and the corners of the register ranges
    apply_settings($urandom_range(0, 511), $urandom_range(0, 255), $urandom_range(0, 200),
                   $urandom_range(0, 5000), $urandom_range(0, 255), $urandom_range(0, 255), 1);
    queue_random(232);
    drain_all();
    apply_settings(0, 0, 0, 0, 0, 0, 1);
    queue_random(232);
    drain_all();
    apply_settings(511, 255, 0, 0, 255, 255, 1);
    queue_random(232);
    drain_all();
    apply_settings(511, 0, 131071, 524287, 255, 0, 0);
    queue_random(232);
    drain_all();
    for (int p = 0; p < 3; p++) begin
      apply_settings($urandom_range(0, 511), $urandom_range(0, 255), $urandom_range(0, 50),
                     $urandom_range(0, 20000), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 1));
      queue_random(232);
      drain_all();
    end

    repeat (20) @(posedge clk);
    $display("Run covered %0d blob words in %0d frames over %0d register settings.",
             n_blobs, n_frames, n_settings);
    $display("%0d steering words checked; left side found %0d times, right side %0d times.",
             n_checked, n_left_hits, n_right_hits);
    if (errors == 0) begin
      $display("nearest_blob_steering verification clean");
    end else begin
      $display("nearest_blob_steering verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("nearest_blob_steering verification failed");
    $finish;
  end

endmodule
